// ----- hdl/atilt_pkg.sv -----
// Package for the accelerometer tilt-angle core: widths, fixed-point constants,
// arctangent table and the pipeline payload types. No dependencies.
`default_nettype none

package atilt_pkg;

  localparam int unsigned DataW          = 16;
  localparam int unsigned FracShift      = 16;
  localparam int unsigned CordW          = 36;
  localparam int unsigned AngW           = 34;
  localparam int unsigned AtanLen        = 24;
  localparam int unsigned CordicStepsDef = 14;

  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [AngW-1:0] AccLimit  = 34'sd4294967295;

  // q30 radians to q16 degrees: q = floor(floor((|r| * DegMul + DegRound) / 256) / DegDiv)
  localparam int unsigned MagW        = AngW - 1;
  localparam int unsigned DegMul      = 5625;
  localparam int unsigned DegMulW     = 13;
  localparam int unsigned DegRound    = 804224;
  localparam int unsigned DegDiv      = 6283;
  localparam int unsigned DegDivW     = 13;
  localparam int unsigned ScaleShift  = 8;
  localparam int unsigned ProdW       = MagW + DegMulW;
  localparam int unsigned PW          = ProdW - ScaleShift;
  localparam int unsigned RecipPre    = 12;
  localparam int unsigned RecipShift  = 26;
  localparam int unsigned RecipW      = 26;
  localparam int unsigned PhW         = PW - RecipPre;
  localparam logic [RecipW-1:0] RecipK =
    RecipW'((64'd1 << (RecipShift + RecipPre)) / DegDiv);
  localparam int unsigned QW          = 24;
  localparam int unsigned RemW        = 15;
  localparam int unsigned DegW        = QW + 1;

  localparam int unsigned GainProdW   = DegW + DataW;
  localparam int unsigned VW          = GainProdW + 1;
  localparam int unsigned TruncShift  = 24;
  localparam int unsigned TW          = VW - TruncShift;
  localparam logic signed [VW-1:0] NinetyQ24 = VW'(64'd90 << TruncShift);

  localparam logic signed [DataW-1:0] GainReset = 16'sd256;
  localparam logic signed [DataW-1:0] Sentinel  = 16'sd404;
  localparam logic signed [DataW-1:0] SatMax    = 16'sh7fff;
  localparam logic signed [DataW-1:0] SatMin    = 16'sh8000;

  typedef struct packed {
    logic x_neg;
    logic x_zero;
    logic z_neg;
  } atilt_flags_t;

  typedef struct packed {
    logic signed [CordW-1:0] cx;
    logic signed [CordW-1:0] cy;
    logic signed [AngW-1:0]  acc;
    atilt_flags_t            flags;
  } atilt_cord_t;

  typedef struct packed {
    logic signed [DegW-1:0] deg;
    logic                   x_neg;
  } atilt_deg_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned idx);
    logic signed [AngW-1:0] val;
    unique case (idx)
      0:       val = 34'sd843314857;
      1:       val = 34'sd497837829;
      2:       val = 34'sd263043837;
      3:       val = 34'sd133525159;
      4:       val = 34'sd67021687;
      5:       val = 34'sd33543516;
      6:       val = 34'sd16775851;
      7:       val = 34'sd8388437;
      8:       val = 34'sd4194283;
      9:       val = 34'sd2097149;
      10:      val = 34'sd1048576;
      11:      val = 34'sd524288;
      12:      val = 34'sd262144;
      13:      val = 34'sd131072;
      14:      val = 34'sd65536;
      15:      val = 34'sd32768;
      16:      val = 34'sd16384;
      17:      val = 34'sd8192;
      18:      val = 34'sd4096;
      19:      val = 34'sd2048;
      20:      val = 34'sd1024;
      21:      val = 34'sd512;
      22:      val = 34'sd256;
      23:      val = 34'sd128;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/atilt_ifs.sv -----
// Valid/ready channel interfaces for the tilt-angle core: sample, result, gain write.
// Depends on atilt_pkg.
`default_nettype none

interface atilt_in_if import atilt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] accel_x;
  logic signed [DataW-1:0] accel_z;
  modport source (output valid, accel_x, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_z, output ready);
endinterface

interface atilt_out_if import atilt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] tilt_degrees;
  logic                    tilt_valid;
  modport source (output valid, tilt_degrees, tilt_valid, input ready);
  modport sink   (input valid, tilt_degrees, tilt_valid, output ready);
endinterface

interface atilt_cfg_if import atilt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] angle_gain;
  modport source (output valid, angle_gain, input ready);
  modport sink   (input valid, angle_gain, output ready);
endinterface

`default_nettype wire

// ----- hdl/accel_tilt_angle_core.sv -----
// Top level of the accelerometer tilt-angle core: gain register, pre-rotation,
// CORDIC chain, degree conversion and output. Depends on atilt_pkg, atilt_ifs and submodules.
//
//   channel    dir   payload                        transfer when
//   sample_i   in    accel_x, accel_z               valid && ready
//   result_o   out   tilt_degrees, tilt_valid       valid && ready
//   cfg_i      in    angle_gain                     valid && ready (ready tied high)
//
// One sample per cycle while result_o is not stalled. Stages: one pre-rotation stage,
// one stage per CORDIC iteration, three for degree conversion, two for gain and output.
// Reset clears all valid bits and loads angle_gain with 1.0 (256).
// Each stage holds its item while the next one cannot take it, so a stall squeezes out
// bubbles and input stays open while any stage is empty.
`default_nettype none

module accel_tilt_angle_core import atilt_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  atilt_in_if.sink   sample_i,
  atilt_out_if.source result_o,
  atilt_cfg_if.sink  cfg_i
);

  logic signed [DataW-1:0] gain_q;
  atilt_cord_t             st_data [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]   st_valid;
  logic [CORDIC_STEPS:0]   st_ready;
  logic                    deg_valid;
  logic                    deg_ready;
  atilt_deg_t              deg_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      gain_q <= cfg_i.angle_gain;
    end
  end

  atilt_prerot u_prerot (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sample_i.valid),
    .ready_o   (sample_i.ready),
    .accel_x_i (sample_i.accel_x),
    .accel_z_i (sample_i.accel_z),
    .valid_o   (st_valid[0]),
    .ready_i   (st_ready[0]),
    .data_o    (st_data[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    atilt_cordic_stage #(
      .Step (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .data_i  (st_data[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  atilt_deg_scale u_deg_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid[CORDIC_STEPS]),
    .ready_o (st_ready[CORDIC_STEPS]),
    .data_i  (st_data[CORDIC_STEPS]),
    .valid_o (deg_valid),
    .ready_i (deg_ready),
    .data_o  (deg_data)
  );

  atilt_gain_out u_gain_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (deg_valid),
    .ready_o        (deg_ready),
    .data_i         (deg_data),
    .gain_i         (gain_q),
    .valid_o        (result_o.valid),
    .ready_i        (result_o.ready),
    .tilt_degrees_o (result_o.tilt_degrees),
    .tilt_valid_o   (result_o.tilt_valid)
  );

  a_sentinel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.tilt_valid |-> result_o.tilt_degrees == Sentinel)
    else $error("invalid result without sentinel value");

  a_input_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> st_valid[0])
    else $error("input refused while first stage is empty");

  a_acc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid[CORDIC_STEPS] |->
      (st_data[CORDIC_STEPS].acc <= AccLimit) && (st_data[CORDIC_STEPS].acc >= -AccLimit))
    else $error("CORDIC angle accumulator out of range");

endmodule

`default_nettype wire

// ----- hdl/atilt_prerot.sv -----
// First pipeline stage: scale the sample, classify signs and pre-rotate into the
// right half plane. Depends on atilt_pkg.
`default_nettype none

module atilt_prerot import atilt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [DataW-1:0] accel_x_i,
  input  logic signed [DataW-1:0] accel_z_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output atilt_cord_t             data_o
);

  atilt_cord_t             data_d;
  atilt_cord_t             data_q;
  logic                    valid_q;
  logic signed [CordW-1:0] x_sc;
  logic signed [CordW-1:0] z_sc;

  assign x_sc = {{(CordW-DataW-FracShift){accel_x_i[DataW-1]}}, accel_x_i, {FracShift{1'b0}}};
  assign z_sc = {{(CordW-DataW-FracShift){accel_z_i[DataW-1]}}, accel_z_i, {FracShift{1'b0}}};

  always_comb begin
    data_d.flags.x_neg  = accel_x_i[DataW-1];
    data_d.flags.x_zero = (accel_x_i == '0);
    data_d.flags.z_neg  = accel_z_i[DataW-1];
    if (accel_z_i[DataW-1]) begin
      data_d.cx  = x_sc;
      data_d.cy  = -z_sc;
      data_d.acc = HalfPiQ30;
    end else begin
      data_d.cx  = z_sc;
      data_d.cy  = x_sc;
      data_d.acc = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- hdl/atilt_cordic_stage.sv -----
// One registered vectoring CORDIC iteration with a fixed shift.
// Depends on atilt_pkg.
`default_nettype none

module atilt_cordic_stage import atilt_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  atilt_cord_t data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output atilt_cord_t data_o
);

  localparam logic signed [AngW-1:0] AtanVal = atan_q30(Step);

  atilt_cord_t             data_d;
  atilt_cord_t             data_q;
  logic                    valid_q;
  logic signed [CordW-1:0] cx;
  logic signed [CordW-1:0] cy;
  logic signed [CordW-1:0] cx_sh;
  logic signed [CordW-1:0] cy_sh;

  assign cx    = data_i.cx;
  assign cy    = data_i.cy;
  assign cx_sh = cx >>> Step;
  assign cy_sh = cy >>> Step;

  always_comb begin
    data_d = data_i;
    if (cy > 0) begin
      data_d.cx  = cx + cy_sh;
      data_d.cy  = cy - cx_sh;
      data_d.acc = data_i.acc + AtanVal;
    end else begin
      data_d.cx  = cx - cy_sh;
      data_d.cy  = cy + cx_sh;
      data_d.acc = data_i.acc - AtanVal;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- hdl/atilt_deg_scale.sv -----
// Three-stage conversion of the q30 radian angle to rounded q16 degrees:
// scale, reciprocal estimate, remainder correction. Depends on atilt_pkg.
`default_nettype none

module atilt_deg_scale import atilt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  atilt_cord_t data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output atilt_deg_t  data_o
);

  // scale
  logic signed [AngW-1:0]  ang;
  logic signed [AngW-1:0]  ang_abs;
  logic [MagW-1:0]         mag;
  logic [ProdW-1:0]        scaled;
  logic                    a_valid_q;
  logic                    a_ready;
  logic [PW-1:0]           a_p_q;
  logic                    a_neg_q;
  logic                    a_xneg_q;

  // reciprocal estimate
  logic [PhW+RecipW-1:0]   recip_prod;
  logic                    b_valid_q;
  logic                    b_ready;
  logic [QW-1:0]           b_qe_q;
  logic [RemW-1:0]         b_plo_q;
  logic                    b_neg_q;
  logic                    b_xneg_q;

  // correction
  logic [QW+DegDivW-1:0]   back_prod;
  logic [RemW-1:0]         rem;
  logic [1:0]              corr;
  logic [DegW-1:0]         q;
  logic signed [DegW-1:0]  deg_d;
  logic                    c_valid_q;
  logic                    c_ready;
  atilt_deg_t              c_data_q;

  always_comb begin
    if (data_i.flags.x_zero) begin
      ang = data_i.flags.z_neg ? PiQ30 : '0;
    end else begin
      ang = data_i.acc;
    end
    ang_abs = ang[AngW-1] ? -ang : ang;
    mag     = ang_abs[MagW-1:0];
    scaled  = ProdW'(mag) * ProdW'(DegMul) + ProdW'(DegRound);
  end

  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_p_q    <= scaled[ProdW-1:ScaleShift];
      a_neg_q  <= ang[AngW-1];
      a_xneg_q <= data_i.flags.x_neg;
    end
  end

  assign recip_prod = (PhW+RecipW)'(a_p_q[PW-1:RecipPre]) * (PhW+RecipW)'(RecipK);
  assign b_ready    = !b_valid_q || c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_qe_q   <= recip_prod[RecipShift +: QW];
      b_plo_q  <= a_p_q[RemW-1:0];
      b_neg_q  <= a_neg_q;
      b_xneg_q <= a_xneg_q;
    end
  end

  // estimate is low by at most two
  always_comb begin
    back_prod = (QW+DegDivW)'(b_qe_q) * (QW+DegDivW)'(DegDiv);
    rem       = b_plo_q - back_prod[RemW-1:0];
    if (rem >= RemW'(2 * DegDiv)) begin
      corr = 2'd2;
    end else if (rem >= RemW'(DegDiv)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    q     = DegW'(b_qe_q) + DegW'(corr);
    deg_d = b_neg_q ? -$signed(q) : $signed(q);
  end

  assign c_ready = !c_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_data_q.deg   <= deg_d;
      c_data_q.x_neg <= b_xneg_q;
    end
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_data_q;

endmodule

`default_nettype wire

// ----- hdl/atilt_gain_out.sv -----
// Gain multiply, then subtract from 90, truncate toward zero, saturate or substitute the
// sentinel for negative x, and output register. Depends on atilt_pkg.
`default_nettype none

module atilt_gain_out import atilt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  atilt_deg_t              data_i,
  input  logic signed [DataW-1:0] gain_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [DataW-1:0] tilt_degrees_o,
  output logic                    tilt_valid_o
);

  logic signed [DegW-1:0]      deg_in;
  logic signed [GainProdW-1:0] prod;
  logic                        d_valid_q;
  logic                        d_ready;
  logic signed [GainProdW-1:0] d_prod_q;
  logic                        d_xneg_q;

  logic signed [VW-1:0]        v;
  logic signed [TW-1:0]        tq;
  logic signed [TW-1:0]        t;
  logic signed [DataW-1:0]     deg_d;
  logic                        e_valid_q;
  logic                        e_ready;
  logic signed [DataW-1:0]     e_deg_q;
  logic                        e_flag_q;

  assign deg_in  = data_i.deg;
  assign prod    = GainProdW'(deg_in) * GainProdW'(gain_i);
  assign d_ready = !d_valid_q || e_ready;
  assign ready_o = d_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_ready) begin
      d_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && valid_i) begin
      d_prod_q <= prod;
      d_xneg_q <= data_i.x_neg;
    end
  end

  always_comb begin
    v  = NinetyQ24 - VW'(d_prod_q);
    tq = $signed(v[VW-1:TruncShift]);
    if (v[VW-1] && (v[TruncShift-1:0] != '0)) begin
      t = tq + TW'(1);
    end else begin
      t = tq;
    end
    if (!t[TW-1] && (|t[TW-2:DataW-1])) begin
      deg_d = SatMax;
    end else if (t[TW-1] && !(&t[TW-2:DataW-1])) begin
      deg_d = SatMin;
    end else begin
      deg_d = t[DataW-1:0];
    end
    if (d_xneg_q) begin
      deg_d = Sentinel;
    end
  end

  assign e_ready = !e_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (e_ready) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && d_valid_q) begin
      e_deg_q  <= deg_d;
      e_flag_q <= !d_xneg_q;
    end
  end

  assign valid_o        = e_valid_q;
  assign tilt_degrees_o = e_deg_q;
  assign tilt_valid_o   = e_flag_q;

endmodule

`default_nettype wire
